/* sv/leb_pkg.sv */
`timescale 1ns / 1ps

package leb_pkg;

  // default text store depth
  localparam int unsigned LEB_DEPTH = 128;

  localparam int unsigned READ_IDX_W = 7;

  // command codes
  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // key codes
  localparam logic [7:0] KEY_BACKSPACE   = 8'd8;
  localparam logic [7:0] KEY_ENTER       = 8'd10;
  localparam logic [7:0] KEY_UP          = 8'd128;
  localparam logic [7:0] KEY_DOWN        = 8'd129;
  localparam logic [7:0] KEY_LEFT        = 8'd130;
  localparam logic [7:0] KEY_RIGHT       = 8'd131;
  localparam logic [7:0] KEY_HOME        = 8'd132;
  localparam logic [7:0] KEY_END         = 8'd133;
  localparam logic [7:0] KEY_MOUSE       = 8'd134;
  localparam logic [7:0] KEY_ASCII_LIMIT = 8'd128;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_READ  = 2'd1,
    S_SHIFT = 2'd2,
    S_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic       editing;
    logic       finished;
    logic       rejected;
    logic [7:0] cursor_out;
    logic [7:0] length_out;
    logic [7:0] read_char;
  } leb_res_t;

endpackage

/* sv/leb_if.sv */
`timescale 1ns / 1ps

interface leb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] key_code;
  logic [6:0] read_index;

  modport source (output valid, output cmd, output key_code, output read_index, input ready);
  modport sink   (input valid, input cmd, input key_code, input read_index, output ready);
endinterface

interface leb_out_if;
  logic       valid;
  logic       ready;
  logic       editing;
  logic       finished;
  logic       rejected;
  logic [7:0] cursor_out;
  logic [7:0] length_out;
  logic [7:0] read_char;

  modport source (output valid, output editing, output finished, output rejected,
                  output cursor_out, output length_out, output read_char, input ready);
  modport sink   (input valid, input editing, input finished, input rejected,
                  input cursor_out, input length_out, input read_char, output ready);
endinterface

/* sv/leb_ram.sv */
`timescale 1ns / 1ps

module leb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/line_edit_buffer.sv */
`timescale 1ns / 1ps
// line editor: text in a single-port-write, registered-read store, cursor and length in flops
// flow: moves, open, clear, rejected keys and reads past the length go from IDLE to DONE; other
//   reads pass through READ first; backspace and insert first run a shift pass in SHIFT over
//   the one-read one-write store ports, moving the characters from the cursor on
// throughput: one item at a time; the next item is taken once the result is in the output reg
// reset: cursor, length and editing flag cleared; the text store itself is not cleared

module line_edit_buffer import leb_pkg::*; #(
  parameter int unsigned DEPTH = LEB_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  leb_in_if.sink   in_i,
  leb_out_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);      // store address width
  localparam int unsigned LW = $clog2(DEPTH + 1);  // cursor / length width
  localparam int unsigned CW = (LW > READ_IDX_W) ? LW : READ_IDX_W;  // compare width
  localparam logic [LW-1:0] LenMax = LW'(DEPTH);

  state_e state_q, state_d;

  // architectural state
  logic [LW-1:0] cursor_q, cursor_d;
  logic [LW-1:0] length_q, length_d;
  logic          editing_q, editing_d;

  // shift sequencer
  logic          dir_dn_q, dir_dn_d;    // 1: backspace (move down), 0: insert (move up)
  logic [AW-1:0] rp_q, rp_d;            // next address to read
  logic [AW-1:0] last_q, last_d;        // final address to read
  logic          rd_more_q, rd_more_d;  // reads still to issue
  logic          wr_pend_q, wr_pend_d;  // read data waiting to be written back
  logic [AW-1:0] wa_q, wa_d;            // write-back address for that data
  logic          ins_q, ins_d;          // key still to drop at the old cursor
  logic [7:0]    key_q, key_d;
  logic [AW-1:0] kaddr_q, kaddr_d;

  // per-item result flags
  logic       fin_q, fin_d;
  logic       rej_q, rej_d;
  logic [7:0] rchar_q, rchar_d;

  // output register
  logic     out_valid_q, out_valid_d;
  leb_res_t out_q, out_d;

  // store port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic in_ready;

  leb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    length_d    = length_q;
    editing_d   = editing_q;
    dir_dn_d    = dir_dn_q;
    rp_d        = rp_q;
    last_d      = last_q;
    rd_more_d   = rd_more_q;
    wr_pend_d   = wr_pend_q;
    wa_d        = wa_q;
    ins_d       = ins_q;
    key_d       = key_q;
    kaddr_d     = kaddr_q;
    fin_d       = fin_q;
    rej_d       = rej_q;
    rchar_d     = rchar_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    in_ready    = 1'b0;

    // result taken downstream
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          fin_d   = 1'b0;
          rej_d   = 1'b0;
          rchar_d = '0;
          state_d = S_DONE;
          case (in_i.cmd)
            CMD_KEY: begin
              if (!editing_q) begin
                rej_d = 1'b1;
              end else begin
                case (in_i.key_code)
                  KEY_BACKSPACE: begin
                    if (cursor_q == '0) begin
                      rej_d = 1'b1;
                    end else begin
                      // tail from the cursor moves down one place
                      cursor_d  = cursor_q - LW'(1);
                      length_d  = length_q - LW'(1);
                      dir_dn_d  = 1'b1;
                      rp_d      = AW'(cursor_q);
                      last_d    = AW'(length_q - LW'(1));
                      rd_more_d = (cursor_q < length_q);
                      wr_pend_d = 1'b0;
                      ins_d     = 1'b0;
                      state_d   = S_SHIFT;
                    end
                  end
                  KEY_LEFT: begin
                    if (cursor_q == '0) begin
                      rej_d = 1'b1;
                    end else begin
                      cursor_d = cursor_q - LW'(1);
                    end
                  end
                  KEY_RIGHT: begin
                    if (cursor_q >= length_q) begin
                      rej_d = 1'b1;
                    end else begin
                      cursor_d = cursor_q + LW'(1);
                    end
                  end
                  KEY_HOME, KEY_UP: begin
                    cursor_d = '0;
                  end
                  KEY_END, KEY_DOWN: begin
                    cursor_d = length_q;
                  end
                  KEY_ENTER, KEY_MOUSE: begin
                    fin_d     = 1'b1;
                    editing_d = 1'b0;
                  end
                  default: begin
                    if ((length_q == LenMax) || (in_i.key_code >= KEY_ASCII_LIMIT)) begin
                      rej_d = 1'b1;
                    end else begin
                      // tail moves up one place from the end, then the key lands
                      cursor_d  = cursor_q + LW'(1);
                      length_d  = length_q + LW'(1);
                      dir_dn_d  = 1'b0;
                      rp_d      = AW'(length_q - LW'(1));
                      last_d    = AW'(cursor_q);
                      rd_more_d = (length_q > cursor_q);
                      wr_pend_d = 1'b0;
                      ins_d     = 1'b1;
                      key_d     = in_i.key_code;
                      kaddr_d   = AW'(cursor_q);
                      state_d   = S_SHIFT;
                    end
                  end
                endcase
              end
            end
            CMD_OPEN: begin
              if (!editing_q) begin
                editing_d = 1'b1;
                cursor_d  = length_q;
              end
            end
            CMD_READ: begin
              // positions at or past the length read as zero
              if (CW'(in_i.read_index) < CW'(length_q)) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_i.read_index);
                state_d   = S_READ;
              end
            end
            default: begin
              length_d = '0;
              cursor_d = '0;
            end
          endcase
        end
      end

      S_READ: begin
        rchar_d = ram_rdata;
        state_d = S_DONE;
      end

      S_SHIFT: begin
        // write back last cycle's read while the next read goes out
        if (wr_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata;
        end
        if (rd_more_q) begin
          ram_re    = 1'b1;
          ram_raddr = rp_q;
          wa_d      = dir_dn_q ? (rp_q - AW'(1)) : (rp_q + AW'(1));
          rp_d      = dir_dn_q ? (rp_q + AW'(1)) : (rp_q - AW'(1));
          wr_pend_d = 1'b1;
          rd_more_d = (rp_q != last_q);
        end else begin
          wr_pend_d = 1'b0;
          if (!wr_pend_q) begin
            if (ins_q) begin
              ram_we    = 1'b1;
              ram_waddr = kaddr_q;
              ram_wdata = key_q;
            end
            ins_d   = 1'b0;
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d        = 1'b1;
          out_d.editing      = editing_q;
          out_d.finished     = fin_q;
          out_d.rejected     = rej_q;
          out_d.cursor_out   = 8'(cursor_q);
          out_d.length_out   = 8'(length_q);
          out_d.read_char    = rchar_q;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      length_q    <= '0;
      editing_q   <= 1'b0;
      rd_more_q   <= 1'b0;
      wr_pend_q   <= 1'b0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      length_q    <= length_d;
      editing_q   <= editing_d;
      rd_more_q   <= rd_more_d;
      wr_pend_q   <= wr_pend_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    dir_dn_q <= dir_dn_d;
    rp_q     <= rp_d;
    last_q   <= last_d;
    wa_q     <= wa_d;
    key_q    <= key_d;
    kaddr_q  <= kaddr_d;
    fin_q    <= fin_d;
    rej_q    <= rej_d;
    rchar_q  <= rchar_d;
    out_q    <= out_d;
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.editing    = out_q.editing;
  assign out_o.finished   = out_q.finished;
  assign out_o.rejected   = out_q.rejected;
  assign out_o.cursor_out = out_q.cursor_out;
  assign out_o.length_out = out_q.length_out;
  assign out_o.read_char  = out_q.read_char;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import leb_pkg::*;

  // a long receiver hold-off, long enough to block several offered items
  localparam int unsigned HOLD_CYCLES  = 600;
  // item count after which the run stops starting random sessions
  localparam int unsigned ITEM_TARGET  = 1450;
  // cycles to wait at the end, beyond the slowest shift pass
  localparam int unsigned DRAIN_CYCLES = 200;
  // watchdog, several times the slowest legal run
  localparam longint unsigned RUN_LIMIT_NS = 64'd15_000_000;

  logic clk_i;
  logic rst_ni;

  leb_in_if  in_if ();
  leb_out_if out_if ();

  line_edit_buffer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // mirror of the editor state, updated when an item is accepted
  logic [7:0] text_mirror [LEB_DEPTH];
  logic [7:0] cur_mirror;
  logic [7:0] len_mirror;
  bit         edit_mirror;

  // results still owed by the block, oldest first
  leb_res_t edit_results_q [$];

  int unsigned mismatch_count;
  int unsigned items_sent;
  // chance in percent that the sender idles before its next item; the receiver uses a third
  int unsigned idle_pct;
  // asks the receiver for one long hold-off
  bit          hold_request;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // expected result of one item; also steps the mirrored state
  function automatic leb_res_t predict_edit(cmd_e c, logic [7:0] k, logic [6:0] idx);
    leb_res_t r;
    int       i;
    r = '0;
    case (c)
      CMD_KEY: begin
        if (!edit_mirror) begin
          // keys are dead while not editing
          r.rejected = 1'b1;
        end else begin
          case (k)
            KEY_BACKSPACE: begin
              if (cur_mirror == 0) begin
                r.rejected = 1'b1;
              end else begin
                // close the gap left of the cursor
                for (i = cur_mirror; i < len_mirror; i++) text_mirror[i-1] = text_mirror[i];
                len_mirror--;
                cur_mirror--;
              end
            end
            KEY_LEFT: begin
              if (cur_mirror == 0) r.rejected = 1'b1;
              else cur_mirror--;
            end
            KEY_RIGHT: begin
              if (cur_mirror >= len_mirror) r.rejected = 1'b1;
              else cur_mirror++;
            end
            KEY_HOME, KEY_UP: cur_mirror = '0;
            KEY_END, KEY_DOWN: cur_mirror = len_mirror;
            KEY_ENTER, KEY_MOUSE: begin
              r.finished  = 1'b1;
              edit_mirror = 1'b0;
            end
            default: begin
              if (len_mirror >= LEB_DEPTH || k >= KEY_ASCII_LIMIT) begin
                // full store or an unsupported code
                r.rejected = 1'b1;
              end else begin
                // open a slot at the cursor and drop the code in
                for (i = len_mirror; i > cur_mirror; i--) text_mirror[i] = text_mirror[i-1];
                text_mirror[cur_mirror] = k;
                cur_mirror++;
                len_mirror++;
              end
            end
          endcase
        end
      end
      CMD_OPEN: begin
        // reopening keeps the cursor where it is
        if (!edit_mirror) begin
          edit_mirror = 1'b1;
          cur_mirror  = len_mirror;
        end
      end
      CMD_READ: begin
        // at or past the length the read gives 0
        if (idx < len_mirror) r.read_char = text_mirror[idx];
      end
      default: begin
        // clear leaves the editing flag alone
        len_mirror = '0;
        cur_mirror = '0;
      end
    endcase
    r.editing    = edit_mirror;
    r.cursor_out = cur_mirror;
    r.length_out = len_mirror;
    return r;
  endfunction

  // idle length: mostly none, sometimes short, now and then long
  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // weighted key mix for editing sessions
  function automatic logic [7:0] rand_key();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 42) return 8'($urandom_range(0, 127));
    if (roll < 55) return KEY_BACKSPACE;
    if (roll < 66) return KEY_LEFT;
    if (roll < 76) return KEY_RIGHT;
    if (roll < 79) return KEY_HOME;
    if (roll < 82) return KEY_UP;
    if (roll < 85) return KEY_END;
    if (roll < 88) return KEY_DOWN;
    if (roll < 90) return KEY_ENTER;
    if (roll < 92) return KEY_MOUSE;
    return 8'($urandom_range(135, 255));
  endfunction

  // read positions mostly inside the text, the rest anywhere
  function automatic logic [6:0] rand_read_index();
    if ($urandom_range(0, 99) < 70) begin
      if (len_mirror >= LEB_DEPTH) return 7'($urandom_range(0, LEB_DEPTH - 1));
      return 7'($urandom_range(0, len_mirror));
    end
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatch_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // offer one item, hold it until accepted, then record what it should produce
  task automatic send_item(cmd_e c, logic [7:0] k, logic [6:0] idx);
    int unsigned gap;
    gap = pick_gap(idle_pct);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= c;
    in_if.key_code   <= k;
    in_if.read_index <= idx;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    edit_results_q.push_back(predict_edit(c, k, idx));
    items_sent++;
  endtask

  // commands while not editing, on an empty store
  task automatic test_idle_commands();
    idle_pct = 30;
    send_item(CMD_READ, 8'h00, 7'd0);
    send_item(CMD_KEY, 8'h61, 7'd0);
    send_item(CMD_KEY, 8'hFF, 7'd127);
    send_item(CMD_CLEAR, 8'h00, 7'd0);
  endtask

  // every key and its bound cases on a short line
  task automatic test_key_edits();
    idle_pct = 30;
    send_item(CMD_OPEN, 8'h00, 7'd0);
    send_item(CMD_KEY, KEY_BACKSPACE, 7'd0);   // nothing left of the cursor
    send_item(CMD_KEY, KEY_LEFT, 7'd0);        // already at the start
    send_item(CMD_KEY, KEY_RIGHT, 7'd0);       // already at the end
    send_item(CMD_KEY, 8'h00, 7'd0);           // lowest accepted code
    send_item(CMD_KEY, 8'h7F, 7'd0);           // highest accepted code
    send_item(CMD_KEY, 8'h41, 7'd0);
    send_item(CMD_KEY, KEY_LEFT, 7'd0);
    send_item(CMD_KEY, 8'h6D, 7'd0);           // insert in the middle
    send_item(CMD_KEY, KEY_UP, 7'd0);
    send_item(CMD_KEY, KEY_RIGHT, 7'd0);
    send_item(CMD_KEY, KEY_BACKSPACE, 7'd0);   // delete with a tail behind it
    send_item(CMD_KEY, KEY_END, 7'd0);
    send_item(CMD_KEY, KEY_HOME, 7'd0);
    send_item(CMD_KEY, KEY_DOWN, 7'd0);
    send_item(CMD_KEY, 8'd135, 7'd0);          // first unsupported code
    send_item(CMD_KEY, 8'hFF, 7'd0);
    send_item(CMD_READ, 8'hFF, 7'd0);
    send_item(CMD_READ, 8'h00, 7'd127);        // beyond the length
    send_item(CMD_KEY, KEY_HOME, 7'd0);
    send_item(CMD_OPEN, 8'h00, 7'd0);          // reopen keeps cursor at 0
    send_item(CMD_KEY, KEY_ENTER, 7'd0);
    send_item(CMD_OPEN, 8'h00, 7'd0);          // cursor jumps to the end
    send_item(CMD_KEY, KEY_MOUSE, 7'd0);
    send_item(CMD_CLEAR, 8'h00, 7'd0);
  endtask

  // fill the store to the top, bounce off it, read both ends
  task automatic test_full_store();
    int unsigned roll;
    idle_pct = 10;
    send_item(CMD_CLEAR, 8'h00, 7'd0);
    if (!edit_mirror) send_item(CMD_OPEN, 8'h00, 7'd0);
    while (len_mirror < LEB_DEPTH) begin
      roll = $urandom_range(0, 15);
      if (roll == 0) send_item(CMD_KEY, KEY_HOME, 7'($urandom_range(0, 127)));
      else if (roll == 1) send_item(CMD_KEY, KEY_LEFT, 7'($urandom_range(0, 127)));
      else send_item(CMD_KEY, 8'($urandom_range(32, 126)), 7'($urandom_range(0, 127)));
    end
    send_item(CMD_KEY, 8'h7A, 7'd0);           // store full
    send_item(CMD_KEY, KEY_END, 7'd0);
    send_item(CMD_KEY, 8'h00, 7'd0);           // still full at the end
    send_item(CMD_READ, 8'h00, 7'd0);
    send_item(CMD_READ, 8'h00, 7'd127);
    repeat (4) send_item(CMD_READ, 8'h00, 7'($urandom_range(0, 127)));
    send_item(CMD_KEY, KEY_HOME, 7'd0);
    send_item(CMD_KEY, KEY_RIGHT, 7'd0);
    send_item(CMD_KEY, KEY_BACKSPACE, 7'd0);   // longest shift down
    send_item(CMD_KEY, 8'h51, 7'd0);           // longest shift up, full again
    send_item(CMD_READ, 8'h00, 7'd0);
    send_item(CMD_KEY, KEY_ENTER, 7'd0);
  endtask

  // receiver stops for a long stretch while items keep coming
  task automatic test_output_stall();
    idle_pct     = 0;
    hold_request = 1'b1;
    if (!edit_mirror) send_item(CMD_OPEN, 8'h00, 7'd0);
    repeat (12) send_item(CMD_KEY, rand_key(), 7'($urandom_range(0, 127)));
    send_item(CMD_READ, 8'h00, rand_read_index());
  endtask

  // editing sessions with random content, plus some raw noise
  task automatic test_random_edits(int unsigned target);
    int unsigned n;
    int unsigned roll;
    while (items_sent < target) begin
      // some sessions run with no idling at all
      idle_pct = ($urandom_range(0, 4) == 0) ? 0 : 30;
      if ($urandom_range(0, 99) < 85) begin
        if (!edit_mirror)
          send_item(CMD_OPEN, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        n = $urandom_range(4, 48);
        repeat (n) begin
          roll = $urandom_range(0, 99);
          if (roll < 10)
            send_item(CMD_READ, 8'($urandom_range(0, 255)), rand_read_index());
          else if (roll < 12)
            send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
          else if (roll < 14)
            send_item(CMD_OPEN, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
          else
            send_item(CMD_KEY, rand_key(), 7'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 3) != 0)
          send_item(CMD_KEY, $urandom_range(0, 1) ? KEY_ENTER : KEY_MOUSE, 7'd0);
      end else begin
        // anything goes, any field, any bit
        repeat ($urandom_range(1, 6))
          send_item(cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)));
      end
    end
  endtask

  // receiver side: random ready gaps, and the one long hold-off on request
  initial begin : result_receiver
    int unsigned gap;
    int unsigned hold_count;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk_i);
      end else begin
        gap = pick_gap(idle_pct / 3);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  // every accepted result against the oldest expectation, field by field
  initial begin : result_checker
    leb_res_t want;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (edit_results_q.size() == 0) begin
          report_mismatch("result with nothing expected", 8'h00, 8'h00);
        end else begin
          want = edit_results_q.pop_front();
          if (out_if.editing !== want.editing)
            report_mismatch("editing", 8'(out_if.editing), 8'(want.editing));
          if (out_if.finished !== want.finished)
            report_mismatch("finished", 8'(out_if.finished), 8'(want.finished));
          if (out_if.rejected !== want.rejected)
            report_mismatch("rejected", 8'(out_if.rejected), 8'(want.rejected));
          if (out_if.cursor_out !== want.cursor_out)
            report_mismatch("cursor_out", out_if.cursor_out, want.cursor_out);
          if (out_if.length_out !== want.length_out)
            report_mismatch("length_out", out_if.length_out, want.length_out);
          if (out_if.read_char !== want.read_char)
            report_mismatch("read_char", out_if.read_char, want.read_char);
        end
      end
    end
  end

  // watchdog: a hung block ends the run here
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_sequence
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_KEY;
    in_if.key_code   = '0;
    in_if.read_index = '0;
    mismatch_count   = 0;
    items_sent       = 0;
    idle_pct         = 0;
    hold_request     = 1'b0;
    cur_mirror       = '0;
    len_mirror       = '0;
    edit_mirror      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_commands();
    test_key_edits();
    test_full_store();
    test_output_stall();
    test_random_edits(ITEM_TARGET);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    // drain what is still owed, then give a stray result time to show up
    while (edit_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
